@@ rtl/trail_ribbon_vertex_gen_assert.svh @@
// ----------------------------------------------------------------------------
// Trail ribbon vertex generator assertion macros
// Concurrent assertion shorthands that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef TRAIL_RIBBON_VERTEX_GEN_ASSERT_SVH
`define TRAIL_RIBBON_VERTEX_GEN_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define TRV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trail ribbon assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define TRV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trail ribbon assertion failed");

`else

`define TRV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TRV_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/trv_pkg.sv @@
// ----------------------------------------------------------------------------
// Trail ribbon vertex generator package
// Shared widths, register indexes, modes and the types passed between units.
// ----------------------------------------------------------------------------
package trv_pkg;

  localparam int COORD_W    = 32;
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 11;
  localparam int MODE_W     = 2;
  localparam int WIDTH_W    = 31;
  localparam int TEXV_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FIFO_DEPTH = 2;

  // 0.99 in unsigned Q0.16, rounded.
  localparam logic [TEXV_W-1:0] V_CLAMP = 16'd64881;
  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_POINTS);
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 31'd65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Z = 3'd5;

  typedef enum logic [MODE_W-1:0] {
    MODE_RIGHT = 2'd0,
    MODE_BILL  = 2'd1,
    MODE_RAW   = 2'd2,
    MODE_OFF   = 2'd3
  } mode_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    mode_t               mode;
    logic [WIDTH_W-1:0]  width;
    logic [CNT_W-1:0]    count;
    coord_t              cam_x;
    coord_t              cam_y;
    coord_t              cam_z;
  } trv_cfg_t;

  // One classified point waiting for the vertex engine.
  typedef struct packed {
    mode_t             mode;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  div;
    coord_t            px;
    coord_t            py;
    coord_t            pz;
    coord_t            ax;
    coord_t            ay;
    coord_t            az;
  } trv_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } trv_fifo_st_t;

endpackage

@@ rtl/trv_if.sv @@
// ----------------------------------------------------------------------------
// Trail ribbon vertex generator channels
// Valid/ready channels for trail points in and vertices out.
// ----------------------------------------------------------------------------
interface trv_in_if;
  import trv_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  coord_t right_x;
  coord_t right_y;
  coord_t right_z;
  coord_t back_x;
  coord_t back_y;
  coord_t back_z;

  modport source (output valid, point_x, point_y, point_z, right_x, right_y, right_z,
                  back_x, back_y, back_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, right_x, right_y, right_z,
                back_x, back_y, back_z, output ready);
endinterface

interface trv_out_if;
  import trv_pkg::*;

  logic              valid;
  logic              ready;
  coord_t            vert_x;
  coord_t            vert_y;
  coord_t            vert_z;
  logic              tex_u;
  logic [TEXV_W-1:0] tex_v;
  logic              run_last;

  modport source (output valid, vert_x, vert_y, vert_z, tex_u, tex_v, run_last,
                  input ready);
  modport sink (input valid, vert_x, vert_y, vert_z, tex_u, tex_v, run_last,
                output ready);
endinterface

@@ rtl/trv_fifo.sv @@
// ----------------------------------------------------------------------------
// Trail ribbon point queue
// Short queue of classified points between the front end and the engine.
// ----------------------------------------------------------------------------
module trv_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  trv_pkg::trv_item_t    push_item,
  input  logic                  pop,
  output trv_pkg::trv_item_t    pop_item,
  output trv_pkg::trv_fifo_st_t st
);
  import trv_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  trv_item_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign pop_item = mem[rd_ptr_r];
  assign st.full  = (cnt_r == (PTR_W+1)'(FIFO_DEPTH));
  assign st.empty = (cnt_r == '0);

endmodule

@@ rtl/trv_front.sv @@
// ----------------------------------------------------------------------------
// Trail ribbon front end
// Holds the configuration, counts points along the trail and queues the
// points that produce vertices.
// ----------------------------------------------------------------------------
module trv_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [trv_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [trv_pkg::CFG_DATA_W-1:0] cfg_wdata,
  trv_in_if.sink                        in_pt,
  output trv_pkg::trv_cfg_t             cfg,
  output logic                          push,
  output trv_pkg::trv_item_t            push_item,
  input  trv_pkg::trv_fifo_st_t         fifo_st
);
  import trv_pkg::*;

  trv_cfg_t         cfg_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] need;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] cur_inc;
  logic             accept;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_RIGHT;
      cfg_r.width <= WIDTH_RST;
      cfg_r.count <= '0;
      cfg_r.cam_x <= '0;
      cfg_r.cam_y <= '0;
      cfg_r.cam_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE:  cfg_r.mode  <= mode_t'(cfg_wdata[MODE_W-1:0]);
        REG_WIDTH: cfg_r.width <= cfg_wdata[WIDTH_W-1:0];
        REG_COUNT: cfg_r.count <= cfg_wdata[CNT_W-1:0];
        REG_CAM_X: cfg_r.cam_x <= coord_t'(cfg_wdata[COORD_W-1:0]);
        REG_CAM_Y: cfg_r.cam_y <= coord_t'(cfg_wdata[COORD_W-1:0]);
        REG_CAM_Z: cfg_r.cam_z <= coord_t'(cfg_wdata[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  // Classify the point: effective count, index wrap and whether it is drawn.
  assign in_pt.ready = !fifo_st.full;
  assign accept      = in_pt.valid && in_pt.ready;
  assign cnt         = (cfg_r.count > MAX_CNT) ? MAX_CNT : cfg_r.count;
  assign need        = (cfg_r.mode == MODE_RAW) ? CNT_W'(4) : CNT_W'(2);
  assign cur         = (CNT_W'(idx_r) >= cnt) ? '0 : CNT_W'(idx_r);
  assign cur_inc     = cur + 1'b1;

  always_comb begin
    idx_nxt = idx_r;
    push    = 1'b0;
    if (accept) begin
      unique case (cfg_r.mode)
        MODE_OFF: ;
        default: begin
          if (cnt < need) begin
            idx_nxt = '0;
          end else begin
            push    = 1'b1;
            idx_nxt = (cur_inc >= cnt) ? '0 : cur_inc[IDX_W-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // Queue entry.
  always_comb begin
    push_item.mode = cfg_r.mode;
    push_item.idx  = cur[IDX_W-1:0];
    push_item.div  = (cfg_r.mode == MODE_RAW) ? cnt : cnt - 1'b1;
    push_item.px   = in_pt.point_x;
    push_item.py   = in_pt.point_y;
    push_item.pz   = in_pt.point_z;
    if (cfg_r.mode == MODE_RIGHT) begin
      push_item.ax = in_pt.right_x;
      push_item.ay = in_pt.right_y;
      push_item.az = in_pt.right_z;
    end else begin
      push_item.ax = in_pt.back_x;
      push_item.ay = in_pt.back_y;
      push_item.az = in_pt.back_z;
    end
  end

endmodule

@@ rtl/trv_back.sv @@
// ----------------------------------------------------------------------------
// Trail ribbon vertex engine
// Sequencer around a shared square root and a four-lane bit-serial divider:
// normalizes the side axis, builds the billboard axis, scales by half the
// width and emits the vertices.
// ----------------------------------------------------------------------------
module trv_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  trv_pkg::trv_cfg_t     cfg,
  input  trv_pkg::trv_item_t    pop_item,
  input  trv_pkg::trv_fifo_st_t fifo_st,
  output logic                  pop,
  trv_out_if.source             out_vx
);
  import trv_pkg::*;

  localparam int MAG_W  = 52;
  localparam int DIFF_W = COORD_W + 1;
  localparam int UNIT_W = 18;
  localparam int Q_W    = 17;
  localparam int XP_W   = UNIT_W + DIFF_W;
  localparam int NRM_W  = 30;
  localparam int SQ_W   = 2 * NRM_W;
  localparam int RAD_W  = 62;
  localparam int LEN_W  = 32;
  localparam int REM_W  = LEN_W + 1;
  localparam int HALF_W = WIDTH_W - 1;
  localparam int SP_W   = Q_W + HALF_W;
  localparam int OFF_W  = COORD_W + 1;
  localparam int LANES  = 4;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_NSTART, S_NSHIFT, S_NSQR, S_NSQRT, S_DINIT, S_NDIV,
    S_CROSS, S_SCALE, S_EMIT_P, S_EMIT_M, S_EMIT_R
  } state_t;

  state_t                   state_r;
  trv_item_t                item_r;
  logic                     pass_r;
  logic [4:0]               cnt_r;
  logic signed [DIFF_W-1:0] d_r   [3];
  logic                     neg_r [3];
  logic [MAG_W-1:0]         mag_r [3];
  logic signed [MAG_W-1:0]  cr_r  [3];
  logic [RAD_W-1:0]         sq_r;
  logic [SQ_W-1:0]          sqp_r;
  logic [RAD_W-1:0]         rad_r;
  logic [RAD_W-1:0]         root_r;
  logic [RAD_W-1:0]         bit_r;
  logic [LEN_W-1:0]         len_r;
  logic [REM_W-1:0]         rem_r [LANES];
  logic [Q_W-1:0]           quo_r [LANES];
  logic signed [UNIT_W-1:0] n_r   [3];
  logic signed [XP_W-1:0]   xp_r;
  logic [SP_W-1:0]          sp_r;
  logic signed [OFF_W-1:0]  off_r [3];
  logic [TEXV_W-1:0]        texv_r;
  logic                     out_valid_r;
  coord_t                   vx_r;
  coord_t                   vy_r;
  coord_t                   vz_r;
  logic                     u_r;
  logic [TEXV_W-1:0]        v_r;
  logic                     last_r;

  logic [MAG_W-1:0]         orv;
  logic [RAD_W-1:0]         sqt;
  logic                     sq_ge;
  logic [RAD_W-1:0]         root_new;
  logic [NRM_W-1:0]         msel;
  logic [REM_W-1:0]         rsh   [LANES];
  logic [REM_W-1:0]         dv    [LANES];
  logic                     qb    [LANES];
  logic [REM_W-1:0]         rem_new [LANES];
  logic [Q_W-1:0]           qn    [LANES];
  logic signed [UNIT_W-1:0] xa;
  logic signed [DIFF_W-1:0] xb;
  logic signed [XP_W-1:0]   xp_full;
  logic [2:0]               pc;
  logic signed [MAG_W-1:0]  xp_ext;
  logic signed [UNIT_W-1:0] nsel;
  logic signed [UNIT_W-1:0] nabs;
  logic [HALF_W-1:0]        half;
  logic [SP_W-1:0]          sp_full;
  logic signed [OFF_W-1:0]  sp_off;
  logic                     out_free;
  logic                     out_load;
  logic signed [MAG_W-1:0]  src   [3];
  coord_t                   pt    [3];
  coord_t                   cam   [3];
  coord_t                   axv   [3];

  // Saturating vertex add or subtract.
  function automatic coord_t sat_vert(coord_t p, logic signed [OFF_W-1:0] off, logic sub);
    logic signed [COORD_W+1:0] s;
    logic signed [COORD_W+1:0] o;
    o = (COORD_W+2)'(off);
    s = (COORD_W+2)'(p) + (sub ? -o : o);
    if (s[COORD_W+1:COORD_W-1] == 3'b000 || s[COORD_W+1:COORD_W-1] == 3'b111) begin
      return s[COORD_W-1:0];
    end else if (s[COORD_W+1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  assign pt[0]  = item_r.px;
  assign pt[1]  = item_r.py;
  assign pt[2]  = item_r.pz;
  assign axv[0] = item_r.ax;
  assign axv[1] = item_r.ay;
  assign axv[2] = item_r.az;
  assign cam[0] = cfg.cam_x;
  assign cam[1] = cfg.cam_y;
  assign cam[2] = cfg.cam_z;
  assign half   = cfg.width[WIDTH_W-1:1];

  // Normalize source: the item's axis on the first pass, the cross product after.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      src[k] = pass_r ? cr_r[k] : MAG_W'(axv[k]);
    end
  end

  assign orv = mag_r[0] | mag_r[1] | mag_r[2];

  // Square-of-component select.
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    msel = mag_r[0][NRM_W-1:0];
      2'd1:    msel = mag_r[1][NRM_W-1:0];
      2'd2:    msel = mag_r[2][NRM_W-1:0];
      default: msel = '0;
    endcase
  end

  // One root bit per cycle.
  assign sqt      = root_r + bit_r;
  assign sq_ge    = (rad_r >= sqt);
  assign root_new = sq_ge ? ((root_r >> 1) + bit_r) : (root_r >> 1);

  // Divider lanes: three unit components and texture v.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (k < 3) begin
        dv[k]  = {1'b0, len_r};
        rsh[k] = {rem_r[k][REM_W-2:0], (cnt_r == '0) ? mag_r[k % 3][0] : 1'b0};
      end else begin
        dv[k]  = REM_W'(item_r.div);
        rsh[k] = {rem_r[k][REM_W-2:0], (cnt_r == '0) ? item_r.idx[0] : 1'b0};
      end
      qb[k]      = (rsh[k] >= dv[k]);
      rem_new[k] = qb[k] ? (rsh[k] - dv[k]) : rsh[k];
      qn[k]      = {quo_r[k][Q_W-2:0], qb[k]};
    end
  end

  // Cross product operand schedule.
  always_comb begin
    case (cnt_r[2:0])
      3'd0:    begin xa = n_r[1]; xb = d_r[2]; end
      3'd1:    begin xa = n_r[2]; xb = d_r[1]; end
      3'd2:    begin xa = n_r[2]; xb = d_r[0]; end
      3'd3:    begin xa = n_r[0]; xb = d_r[2]; end
      3'd4:    begin xa = n_r[0]; xb = d_r[1]; end
      3'd5:    begin xa = n_r[1]; xb = d_r[0]; end
      default: begin xa = '0;     xb = '0;     end
    endcase
  end

  assign xp_full = xa * xb;
  assign pc      = cnt_r[2:0] - 3'd1;
  assign xp_ext  = MAG_W'(xp_r);

  // Offset scaling: one component per cycle.
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    nsel = n_r[0];
      2'd1:    nsel = n_r[1];
      2'd2:    nsel = n_r[2];
      default: nsel = '0;
    endcase
  end

  assign nabs    = nsel[UNIT_W-1] ? -nsel : nsel;
  assign sp_full = SP_W'(nabs[Q_W-1:0]) * SP_W'(half);
  assign sp_off  = OFF_W'(sp_r[SP_W-1:16]);
  assign out_free = !out_valid_r || out_vx.ready;
  assign out_load = out_free &&
                    (state_r == S_EMIT_P || state_r == S_EMIT_M || state_r == S_EMIT_R);
  assign pop     = (state_r == S_IDLE) && !fifo_st.empty;

  // Sequencer with its datapath and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_vx.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!fifo_st.empty) begin
            item_r  <= pop_item;
            pass_r  <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int k = 0; k < 3; k++) begin
            d_r[k] <= DIFF_W'(pt[k]) - DIFF_W'(cam[k]);
          end
          if (item_r.mode == MODE_RAW) begin
            for (int k = 0; k < 3; k++) begin
              mag_r[k] <= '0;
              neg_r[k] <= 1'b0;
            end
            len_r   <= LEN_W'(1);
            state_r <= S_DINIT;
          end else begin
            state_r <= S_NSTART;
          end
        end
        S_NSTART: begin
          for (int k = 0; k < 3; k++) begin
            neg_r[k] <= src[k][MAG_W-1];
            mag_r[k] <= src[k][MAG_W-1] ? MAG_W'(-src[k]) : MAG_W'(src[k]);
          end
          state_r <= S_NSHIFT;
        end
        S_NSHIFT: begin
          // Bring the largest magnitude into [2^29, 2^30).
          if (orv == '0) begin
            len_r   <= LEN_W'(1);
            state_r <= S_DINIT;
          end else if (|orv[MAG_W-1:38]) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 8;
          end else if (|orv[MAG_W-1:30]) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
          end else if (orv[MAG_W-1:21] == '0) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 8;
          end else if (orv[MAG_W-1:29] == '0) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
          end else begin
            sq_r    <= '0;
            cnt_r   <= '0;
            state_r <= S_NSQR;
          end
        end
        S_NSQR: begin
          sqp_r <= msel * msel;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r != '0) begin
            sq_r <= sq_r + RAD_W'(sqp_r);
          end
          if (cnt_r == 5'd3) begin
            rad_r   <= sq_r + RAD_W'(sqp_r);
            root_r  <= '0;
            bit_r   <= RAD_W'(1) << (RAD_W - 2);
            state_r <= S_NSQRT;
          end
        end
        S_NSQRT: begin
          if (sq_ge) begin
            rad_r <= rad_r - sqt;
          end
          root_r <= root_new;
          bit_r  <= bit_r >> 2;
          if (bit_r == RAD_W'(1)) begin
            len_r   <= root_new[LEN_W-1:0];
            state_r <= S_DINIT;
          end
        end
        S_DINIT: begin
          for (int k = 0; k < 3; k++) begin
            rem_r[k] <= REM_W'(mag_r[k][NRM_W-1:1]);
            quo_r[k] <= '0;
          end
          rem_r[3] <= REM_W'(item_r.idx[IDX_W-1:1]);
          quo_r[3] <= '0;
          cnt_r    <= '0;
          state_r  <= S_NDIV;
        end
        S_NDIV: begin
          for (int k = 0; k < LANES; k++) begin
            rem_r[k] <= rem_new[k];
            quo_r[k] <= qn[k];
          end
          cnt_r <= (cnt_r == 5'(Q_W - 1)) ? '0 : cnt_r + 1'b1;
          if (cnt_r == 5'(Q_W - 1)) begin
            for (int k = 0; k < 3; k++) begin
              n_r[k] <= neg_r[k] ? -UNIT_W'(qn[k]) : UNIT_W'(qn[k]);
            end
            texv_r <= (qn[3] > Q_W'(V_CLAMP)) ? V_CLAMP : qn[3][TEXV_W-1:0];
            if (item_r.mode == MODE_RAW) begin
              state_r <= S_EMIT_R;
            end else if (item_r.mode == MODE_BILL && !pass_r) begin
              for (int k = 0; k < 3; k++) cr_r[k] <= '0;
              state_r <= S_CROSS;
            end else begin
              state_r <= S_SCALE;
            end
          end
        end
        S_CROSS: begin
          // Six products, each registered and accumulated in the cycle after it is formed.
          xp_r  <= xp_full;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r != '0) begin
            case (pc[2:1])
              2'd0:    cr_r[0] <= cr_r[0] + (pc[0] ? -xp_ext : xp_ext);
              2'd1:    cr_r[1] <= cr_r[1] + (pc[0] ? -xp_ext : xp_ext);
              default: cr_r[2] <= cr_r[2] + (pc[0] ? -xp_ext : xp_ext);
            endcase
          end
          if (cnt_r == 5'd6) begin
            pass_r  <= 1'b1;
            state_r <= S_NSTART;
          end
        end
        S_SCALE: begin
          sp_r  <= sp_full;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r != '0) begin
            case (pc[1:0])
              2'd0:    off_r[0] <= n_r[0][UNIT_W-1] ? -sp_off : sp_off;
              2'd1:    off_r[1] <= n_r[1][UNIT_W-1] ? -sp_off : sp_off;
              default: off_r[2] <= n_r[2][UNIT_W-1] ? -sp_off : sp_off;
            endcase
          end
          if (cnt_r == 5'd3) begin
            state_r <= S_EMIT_P;
          end
        end
        S_EMIT_P: begin
          if (out_free) begin
            vx_r    <= sat_vert(pt[0], off_r[0], 1'b0);
            vy_r    <= sat_vert(pt[1], off_r[1], 1'b0);
            vz_r    <= sat_vert(pt[2], off_r[2], 1'b0);
            u_r     <= 1'b0;
            v_r     <= texv_r;
            last_r  <= 1'b0;
            state_r <= S_EMIT_M;
          end
        end
        S_EMIT_M: begin
          if (out_free) begin
            vx_r    <= sat_vert(pt[0], off_r[0], 1'b1);
            vy_r    <= sat_vert(pt[1], off_r[1], 1'b1);
            vz_r    <= sat_vert(pt[2], off_r[2], 1'b1);
            u_r     <= 1'b1;
            v_r     <= texv_r;
            last_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_EMIT_R: begin
          if (out_free) begin
            vx_r    <= pt[0];
            vy_r    <= pt[1];
            vz_r    <= pt[2];
            u_r     <= item_r.idx[0];
            v_r     <= texv_r;
            last_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_vx.valid    = out_valid_r;
  assign out_vx.vert_x   = vx_r;
  assign out_vx.vert_y   = vy_r;
  assign out_vx.vert_z   = vz_r;
  assign out_vx.tex_u    = u_r;
  assign out_vx.tex_v    = v_r;
  assign out_vx.run_last = last_r;

endmodule

@@ rtl/trail_ribbon_vertex_gen.sv @@
// ----------------------------------------------------------------------------
// Trail ribbon vertex generator
// Turns trail points into triangle-strip vertices with texture coordinates.
// ----------------------------------------------------------------------------
// Each accepted point is classified by the front end and queued (two
// entries) for the vertex engine, so points keep flowing in while a vertex
// waits at the output. A raw strip point runs only the 17-step bit-serial
// texture divider. A right-axis ribbon point adds normalizing shifts, the
// shared square root, which yields one result bit per cycle, and the
// four-lane divider, one quotient bit per cycle, then scaling. A billboard
// point runs the normalization twice with the cross product between them.
// Points that emit nothing are absorbed by the front end and never queued.
// ----------------------------------------------------------------------------
`include "trail_ribbon_vertex_gen_assert.svh"

module trail_ribbon_vertex_gen (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [trv_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [trv_pkg::CFG_DATA_W-1:0] cfg_wdata,
  trv_in_if.sink                         in_pt,
  trv_out_if.source                      out_vx
);
  import trv_pkg::*;

  trv_cfg_t     cfg;
  logic         push;
  logic         pop;
  trv_item_t    push_item;
  trv_item_t    pop_item;
  trv_fifo_st_t fifo_st;

  // Configuration and point classification.
  trv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_pt     (in_pt),
    .cfg       (cfg),
    .push      (push),
    .push_item (push_item),
    .fifo_st   (fifo_st)
  );

  // Queue between front end and engine.
  trv_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .st        (fifo_st)
  );

  // Vertex engine.
  trv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .pop_item (pop_item),
    .fifo_st  (fifo_st),
    .pop      (pop),
    .out_vx   (out_vx)
  );

  // The front end never queues into a full queue.
  `TRV_ASSERT_IMP(a_no_push_full, clk, rst_n, fifo_st.full, !push)
  // The engine only takes an entry that is there.
  `TRV_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !fifo_st.empty)
  // The minus vertex follows right after the plus vertex is taken.
  `TRV_ASSERT_NXT(a_pair_follows, clk, rst_n, out_vx.valid && out_vx.ready && !out_vx.run_last, out_vx.valid)
  // A vertex that is not the last of its point is always the plus vertex.
  `TRV_ASSERT_IMP(a_plus_u_zero, clk, rst_n, out_vx.valid && !out_vx.run_last, !out_vx.tex_u)

endmodule

@@ verif/trail_ribbon_vertex_gen_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail ribbon vertex generator checker
// Watches the register port and both channels, predicts the vertices of each
// accepted trail point and compares every output beat field by field.
// ----------------------------------------------------------------------------
module trail_ribbon_vertex_gen_checker
  import trv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  trv_in_if                     in_mon,
  trv_out_if                    out_mon,
  output int                    errors,
  output int                    pending,
  output int                    vertices_seen
);

  typedef struct {
    coord_t            x;
    coord_t            y;
    coord_t            z;
    logic              u;
    logic [TEXV_W-1:0] v;
    logic              last;
  } vertex_t;

  typedef longint vec3_t[3];

  vertex_t vertex_q[$];

  // Shadow copy of the block's registers and point counter.
  mode_t              mode_r;
  logic [WIDTH_W-1:0] width_r;
  logic [CNT_W-1:0]   count_r;
  coord_t             cam_x_r;
  coord_t             cam_y_r;
  coord_t             cam_z_r;
  int unsigned        next_idx;

  assign pending = vertex_q.size();

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Unit vector in Q16.16; magnitudes are first scaled to [2^29, 2^30).
  function automatic void unit_vec(input vec3_t c, output vec3_t n);
    longint unsigned m[3];
    longint unsigned mx;
    longint unsigned len;
    longint unsigned q;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = (c[k] < 0) ? longint'(-c[k]) : longint'(c[k]);
      if (m[k] > mx) mx = m[k];
    end
    if (mx == 0) begin
      n = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
    end
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int k = 0; k < 3; k++) begin
      q = (m[k] << 16) / len;
      n[k] = (c[k] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic coord_t clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return coord_t'(v);
  endfunction

  function automatic logic [TEXV_W-1:0] tex_along(input int unsigned i, input int unsigned d);
    longint unsigned v;
    v = (longint'(i) << 16) / d;
    return (v > V_CLAMP) ? V_CLAMP : TEXV_W'(v);
  endfunction

  // Works out the vertices of one trail point and queues them.
  task automatic predict_vertices(input coord_t p_in[3], input coord_t r_in[3],
                                  input coord_t b_in[3]);
    int unsigned cnt;
    int unsigned need;
    int unsigned i;
    longint p[3];
    vec3_t ax, n, bn, dv, cr;
    longint unsigned half;
    longint unsigned mag;
    longint off;
    vertex_t plus_v, minus_v;
    logic [TEXV_W-1:0] tv;
    if (mode_r == MODE_OFF) return;
    cnt = (count_r > MAX_POINTS) ? MAX_POINTS : count_r;
    need = (mode_r == MODE_RAW) ? 4 : 2;
    if (cnt < need) begin
      next_idx = 0;
      return;
    end
    if (next_idx >= cnt) next_idx = 0;
    i = next_idx;
    next_idx = (i + 1 >= cnt) ? 0 : i + 1;
    for (int k = 0; k < 3; k++) p[k] = p_in[k];

    if (mode_r == MODE_RAW) begin
      plus_v = '{x: p_in[0], y: p_in[1], z: p_in[2], u: i[0],
                 v: tex_along(i, cnt), last: 1'b1};
      vertex_q.push_back(plus_v);
      return;
    end

    if (mode_r == MODE_RIGHT) begin
      for (int k = 0; k < 3; k++) ax[k] = r_in[k];
      unit_vec(ax, n);
    end else begin
      for (int k = 0; k < 3; k++) ax[k] = b_in[k];
      unit_vec(ax, bn);
      dv[0] = p[0] - longint'(cam_x_r);
      dv[1] = p[1] - longint'(cam_y_r);
      dv[2] = p[2] - longint'(cam_z_r);
      cr[0] = bn[1] * dv[2] - bn[2] * dv[1];
      cr[1] = bn[2] * dv[0] - bn[0] * dv[2];
      cr[2] = bn[0] * dv[1] - bn[1] * dv[0];
      unit_vec(cr, n);
    end

    half = width_r >> 1;
    tv = tex_along(i, cnt - 1);
    plus_v = '{x: 0, y: 0, z: 0, u: 1'b0, v: tv, last: 1'b0};
    minus_v = '{x: 0, y: 0, z: 0, u: 1'b1, v: tv, last: 1'b1};
    for (int k = 0; k < 3; k++) begin
      mag = (n[k] < 0) ? longint'(-n[k]) : longint'(n[k]);
      off = longint'((mag * half) >> 16);
      if (n[k] < 0) off = -off;
      case (k)
        0: begin plus_v.x = clip32(p[k] + off); minus_v.x = clip32(p[k] - off); end
        1: begin plus_v.y = clip32(p[k] + off); minus_v.y = clip32(p[k] - off); end
        default: begin plus_v.z = clip32(p[k] + off); minus_v.z = clip32(p[k] - off); end
      endcase
    end
    vertex_q.push_back(plus_v);
    vertex_q.push_back(minus_v);
  endtask

  // Register writes, predictions and comparisons, all on the rising edge.
  always @(posedge clk) begin
    vertex_t want;
    coord_t pv[3], rv[3], bv[3];
    if (!rst_n) begin
      mode_r <= MODE_RIGHT;
      width_r <= WIDTH_RST;
      count_r <= '0;
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      next_idx = 0;
      vertex_q.delete();
      errors <= 0;
      vertices_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MODE:  mode_r <= mode_t'(cfg_wdata[MODE_W-1:0]);
          REG_WIDTH: width_r <= cfg_wdata[WIDTH_W-1:0];
          REG_COUNT: count_r <= cfg_wdata[CNT_W-1:0];
          REG_CAM_X: cam_x_r <= coord_t'(cfg_wdata);
          REG_CAM_Y: cam_y_r <= coord_t'(cfg_wdata);
          REG_CAM_Z: cam_z_r <= coord_t'(cfg_wdata);
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        pv = '{in_mon.point_x, in_mon.point_y, in_mon.point_z};
        rv = '{in_mon.right_x, in_mon.right_y, in_mon.right_z};
        bv = '{in_mon.back_x, in_mon.back_y, in_mon.back_z};
        predict_vertices(pv, rv, bv);
      end
      if (out_mon.valid && out_mon.ready) begin
        vertices_seen <= vertices_seen + 1;
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected vertex beat x=%0d y=%0d z=%0d", $time,
                   out_mon.vert_x, out_mon.vert_y, out_mon.vert_z);
          errors <= errors + 1;
        end else begin
          want = vertex_q.pop_front();
          if (out_mon.vert_x !== want.x || out_mon.vert_y !== want.y ||
              out_mon.vert_z !== want.z || out_mon.tex_u !== want.u ||
              out_mon.tex_v !== want.v || out_mon.run_last !== want.last) begin
            $display("%0t: vertex mismatch expected x=%0d y=%0d z=%0d u=%0d v=%0d last=%0d",
                     $time, want.x, want.y, want.z, want.u, want.v, want.last);
            $display("%0t:                 actual   x=%0d y=%0d z=%0d u=%0d v=%0d last=%0d",
                     $time, out_mon.vert_x, out_mon.vert_y, out_mon.vert_z,
                     out_mon.tex_u, out_mon.tex_v, out_mon.run_last);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ verif/trail_ribbon_vertex_gen_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail ribbon vertex generator testbench
// Writes trail settings, feeds directed and random trail points under varying
// source gaps and sink stalls, and leaves the checking to the checker.
// ----------------------------------------------------------------------------
module trail_ribbon_vertex_gen_tb;
  import trv_pkg::*;

  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 20000;
  localparam int POINT_TARGET = 1900;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  trv_in_if  in_pt ();
  trv_out_if out_vx ();

  int errors;
  int pending;
  int vertices_seen;
  int points_sent;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  int mode_hits[4];

  trail_ribbon_vertex_gen uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_pt     (in_pt),
    .out_vx    (out_vx)
  );

  trail_ribbon_vertex_gen_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_mon        (in_pt),
    .out_mon       (out_vx),
    .errors        (errors),
    .pending       (pending),
    .vertices_seen (vertices_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Sink side: random stalls at the rate of the current phase.
  initial out_vx.ready = 1'b0;
  always @(posedge clk) begin
    out_vx.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog on cycles where no beat moves on either channel and no register is written.
  always @(posedge clk) begin
    if ((in_pt.valid && in_pt.ready) || (out_vx.valid && out_vx.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired at %0t", $time);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Waits until the block is idle, then rewrites every register.
  task automatic set_trail(input mode_t mode, input logic [WIDTH_W-1:0] width,
                           input logic [CNT_W-1:0] cnt, input coord_t cx,
                           input coord_t cy, input coord_t cz);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_WIDTH, CFG_DATA_W'(width));
    write_reg(REG_COUNT, CFG_DATA_W'(cnt));
    write_reg(REG_CAM_X, cx);
    write_reg(REG_CAM_Y, cy);
    write_reg(REG_CAM_Z, cz);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Presents one point, with random gaps, and holds it until accepted.
  task automatic send_point(input coord_t px, input coord_t py, input coord_t pz,
                            input coord_t rx, input coord_t ry, input coord_t rz,
                            input coord_t bx, input coord_t by, input coord_t bz);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_pt.valid <= 1'b0;
      @(posedge clk);
    end
    in_pt.valid <= 1'b1;
    in_pt.point_x <= px;
    in_pt.point_y <= py;
    in_pt.point_z <= pz;
    in_pt.right_x <= rx;
    in_pt.right_y <= ry;
    in_pt.right_z <= rz;
    in_pt.back_x <= bx;
    in_pt.back_y <= by;
    in_pt.back_z <= bz;
    do @(posedge clk); while (!in_pt.ready);
    points_sent++;
  endtask

  task automatic end_burst();
    in_pt.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coord_t any_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3, 4: return coord_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_random_point();
    coord_t r[3];
    coord_t b[3];
    for (int k = 0; k < 3; k++) begin
      r[k] = any_coord();
      b[k] = any_coord();
    end
    // Now and then a zero-length axis.
    if ($urandom_range(0, 15) == 0) r = '{0, 0, 0};
    if ($urandom_range(0, 15) == 0) b = '{0, 0, 0};
    send_point(any_coord(), any_coord(), any_coord(), r[0], r[1], r[2], b[0], b[1], b[2]);
  endtask

  initial begin
    mode_t m;
    logic [WIDTH_W-1:0] w;
    logic [CNT_W-1:0] cnt;
    int n_pts;
    int phase;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_pt.valid = 1'b0;
    in_pt.point_x = '0;
    in_pt.point_y = '0;
    in_pt.point_z = '0;
    in_pt.right_x = '0;
    in_pt.right_y = '0;
    in_pt.right_z = '0;
    in_pt.back_x = '0;
    in_pt.back_y = '0;
    in_pt.back_z = '0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    points_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings with a short trail: nothing comes out.
    send_point(1, 2, 3, 4, 5, 6, 7, 8, 9);
    end_burst();

    // Right-axis ribbon, widest width, extreme coordinates and a zero axis.
    set_trail(MODE_RIGHT, 31'h7fffffff, 11'd2, 0, 0, 0);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
               32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0, 0, 0);
    send_point(0, 0, 0, 1, 0, 0, 0, 0, 0);
    send_point(-1, -1, -1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    end_burst();

    // Count beyond the point limit is clamped.
    set_trail(MODE_RIGHT, 31'd0, 11'h7ff, 0, 0, 0);
    send_random_point();
    send_random_point();
    end_burst();

    // Billboard with the camera at the corners of the range.
    set_trail(MODE_BILL, 31'd131072, 11'd3, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0, 0,
               32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_point(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_point(65536, 0, 0, 0, 0, 0, 0, 0, 65536);
    end_burst();

    // Raw strip across the end of the trail, then too short a strip.
    set_trail(MODE_RAW, 31'd65536, 11'd4, 0, 0, 0);
    repeat (5) send_random_point();
    end_burst();
    set_trail(MODE_RAW, 31'd65536, 11'd3, 0, 0, 0);
    send_random_point();
    end_burst();

    // Unused mode swallows points without touching the index.
    set_trail(MODE_OFF, 31'd65536, 11'd8, 0, 0, 0);
    send_random_point();
    send_random_point();
    end_burst();

    // Index left past a newly shortened count restarts at zero.
    set_trail(MODE_RIGHT, 31'd65536, 11'd10, 0, 0, 0);
    repeat (5) send_random_point();
    end_burst();
    set_trail(MODE_RIGHT, 31'd65536, 11'd3, 0, 0, 0);
    repeat (2) send_random_point();
    end_burst();

    // Random trails under rotating gap and stall patterns.
    phase = 0;
    while (points_sent < POINT_TARGET) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      case ($urandom_range(0, 19))
        0, 1: m = MODE_OFF;
        2, 3, 4, 5, 6, 7: m = MODE_BILL;
        8, 9, 10, 11, 12: m = MODE_RAW;
        default: m = MODE_RIGHT;
      endcase
      case ($urandom_range(0, 9))
        0: w = '0;
        1: w = 31'h7fffffff;
        2, 3: w = WIDTH_W'($urandom);
        default: w = WIDTH_W'($urandom_range(0, 1 << 20));
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2: cnt = CNT_W'($urandom_range(0, 3));
        3, 4: cnt = CNT_W'($urandom_range(10, 40));
        5: cnt = CNT_W'($urandom_range(1000, 2047));
        default: cnt = CNT_W'($urandom_range(2, 9));
      endcase
      mode_hits[m]++;
      set_trail(m, w, cnt, any_coord(), any_coord(), any_coord());
      n_pts = (cnt > 20) ? $urandom_range(5, 25) : 2 * cnt + $urandom_range(1, 4);
      repeat (n_pts) send_random_point();
      end_burst();
      phase++;
    end

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d trail points over %0d random trail settings, checked %0d vertices.",
             points_sent, phase, vertices_seen);
    $display("Random settings per mode: ribbon %0d, billboard %0d, raw %0d, unused %0d.",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
